/* rtl/olisd_pkg.sv */
// Shared types, codes and defaults for the ordered list block.
`timescale 1ns / 1ps
package olisd_pkg;

  localparam int CAP_DEFAULT = 16;
  localparam int LEN_W = 5;

  // Request operation codes.
  localparam logic [1:0] OP_INS_FRONT = 2'd0;
  localparam logic [1:0] OP_INS_BACK  = 2'd1;
  localparam logic [1:0] OP_SEARCH    = 2'd2;
  localparam logic [1:0] OP_DELETE    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [LEN_W-1:0] length;
  } rsp_t;

  // Decoded request as it travels from the front part to the back part.
  typedef struct packed {
    logic               ins;
    logic               at_front;
    logic               del;
    logic signed [31:0] value;
  } cmd_t;

endpackage

/* rtl/olisd_front.sv */
// Front part: accepts requests, decodes them and queues them for the back part.
`timescale 1ns / 1ps
module olisd_front
  import olisd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec = '0;
    dec.value = req.value;
    case (req.op)
      OP_INS_FRONT: begin
        dec.ins = 1'b1;
        dec.at_front = 1'b1;
      end
      OP_INS_BACK: begin
        dec.ins = 1'b1;
      end
      OP_DELETE: begin
        dec.del = 1'b1;
      end
      default: begin
        // Search: neither insert nor delete.
      end
    endcase
  end

  assign req_stall = (fill == 2'd2);
  assign push = req_valid && !req_stall;
  assign cmd_valid = (fill != 2'd0);
  assign pop = cmd_valid && cmd_take;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* rtl/olisd_back.sv */
// Back part: list memory, scan and shift sequencer, and the result register.
`timescale 1ns / 1ps
module olisd_back
  import olisd_pkg::*;
#(
  parameter int CAPACITY = CAP_DEFAULT
)
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_W = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic [1:0]    state;
  cmd_t          cur;
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          rd_vld;
  logic [IW-1:0] rd_tag;
  logic          hit;

  logic          issue;
  logic          match;
  logic          full;
  logic          out_free;
  logic          finish;
  logic          do_ins;
  logic [IW-1:0] head_dec;
  logic [CW-1:0] count_after;

  // Logical position to physical address in the circular store.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[IW-1:0];
  endfunction

  assign issue = (idx < count);
  assign match = rd_vld && (rd_data == cur.value);
  assign full = (count == CAP_C);
  assign out_free = !rsp_valid || !rsp_stall;
  assign finish = (state == S_FIN) && out_free;
  assign do_ins = cur.ins && !full;
  assign head_dec = (head == '0) ? IW'(CAPACITY - 1) : head - 1'b1;
  assign count_after = (finish && do_ins) ? count + 1'b1 : count;
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign rd_addr = phys(head, idx[IW-1:0]);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = phys(head, rd_tag);
    wr_data = rd_data;
    if (state == S_SHIFT && rd_vld) begin
      wr_en = 1'b1;
    end else if (finish && do_ins) begin
      wr_en = 1'b1;
      wr_addr = cur.at_front ? head_dec : phys(head, count[IW-1:0]);
      wr_data = cur.value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      count <= '0;
      idx <= '0;
      rd_vld <= 1'b0;
      rd_tag <= '0;
      hit <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          rd_vld <= 1'b0;
          if (cmd_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads are issued one ahead of the compare.
          if (match) begin
            hit <= 1'b1;
            rd_vld <= 1'b0;
            if (cur.del) begin
              idx <= CW'(rd_tag) + 1'b1;
              rd_tag <= rd_tag;
              state <= S_SHIFT;
            end else begin
              state <= S_FIN;
            end
          end else if (!issue && !rd_vld) begin
            hit <= 1'b0;
            state <= S_FIN;
          end else begin
            if (issue) begin
              idx <= idx + 1'b1;
            end
            rd_vld <= issue;
            rd_tag <= idx[IW-1:0];
          end
        end
        S_SHIFT: begin
          // Each entry behind the removed one moves one place to the front.
          if (!issue && !rd_vld) begin
            count <= count - 1'b1;
            state <= S_FIN;
          end else begin
            if (issue) begin
              idx <= idx + 1'b1;
              rd_tag <= idx[IW-1:0] - 1'b1;
            end
            rd_vld <= issue;
          end
        end
        default: begin
          if (out_free) begin
            if (do_ins) begin
              count <= count + 1'b1;
              if (cur.at_front) begin
                head <= head_dec;
              end
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (cur.ins) begin
        rsp.status <= full ? ST_FULL : ST_DONE;
      end else begin
        rsp.status <= hit ? ST_DONE : ST_NOMATCH;
      end
      rsp.found <= hit;
      rsp.length <= LEN_W'(count_after);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

/* rtl/ordered_list_insert_search_delete.sv */
// Top level of the bounded ordered list: front decode queue and back sequencer.
//
//   channel  valid      stall      payload  meaning
//   request  req_valid  req_stall  req      op and value, accepted when valid && !stall
//   result   rsp_valid  rsp_stall  rsp      status, found, length, one per request
//
// A request passes through the back part in order: it is taken from the queue, the
// scan runs through the list memory (one read port, one entry per cycle, each read
// registered ahead of its compare), and the request finishes. A match ends the scan
// early, and an empty list ends it before any compare.
// A delete that matches then moves the entries behind it forward, one place each,
// with no moves when it removes the last entry.
// Reset clears the length and pointers; the list memory itself is not cleared.
// The two-entry request queue keeps taking requests while a result waits on rsp_stall,
// until both of its entries are taken.
`timescale 1ns / 1ps
module ordered_list_insert_search_delete
  import olisd_pkg::*;
#(
  parameter int CAPACITY = CAP_DEFAULT
)
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  olisd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  olisd_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
